/* rtl/core/crbt_pkg.sv */
// Shared types, codes and command/status bundles for the chunk receive bitmap tracker.
`default_nettype none

package crbt_pkg;

  localparam int WORD_BITS = 64;
  localparam int OFF_W     = 6;
  localparam int RUN_W     = 7;
  localparam int WM_W      = 14;

  localparam logic       KIND_START = 1'b0;
  localparam logic       KIND_MARK  = 1'b1;

  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_TOTAL = 2'd1;
  localparam logic [1:0] ERR_INDEX = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [15:0] chunk_index;
    logic [15:0] total_chunks;
  } item_t;

  typedef struct packed {
    logic            all_received;
    logic [WM_W-1:0] watermark;
    logic [1:0]      error;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic clear;
    logic set_total;
    logic rd_mark;
    logic wr_mark;
    logic rd_walk;
    logic step_walk;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic err;
    logic is_start;
    logic walk_more;
    logic walk_cont;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/crbt_item_if.sv */
// Valid/ready channel that carries one input item.
`default_nettype none

interface crbt_item_if
  import crbt_pkg::*;
  ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/crbt_result_if.sv */
// Valid/ready channel that carries one result item.
`default_nettype none

interface crbt_result_if
  import crbt_pkg::*;
  ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* rtl/core/crbt_ctrl.sv */
// Controller state machine: sequences decode, bitmap update and watermark walk.
`default_nettype none

module crbt_ctrl
  import crbt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  output logic         result_valid,
  input  wire logic    result_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_MWR    = 3'd2;
  localparam logic [2:0] S_WRD    = 3'd3;
  localparam logic [2:0] S_WEVAL  = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (status.err) begin
          state_next = S_DONE;
        end else if (status.is_start) begin
          cmd.clear  = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.set_total = 1'b1;
          cmd.rd_mark   = 1'b1;
          state_next    = S_MWR;
        end
      end
      S_MWR: begin
        cmd.wr_mark = 1'b1;
        state_next  = S_WRD;
      end
      S_WRD: begin
        if (status.walk_more) begin
          cmd.rd_walk = 1'b1;
          state_next  = S_WEVAL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WEVAL: begin
        cmd.step_walk = 1'b1;
        state_next    = status.walk_cont ? S_WRD : S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/crbt_datapath.sv */
// Datapath: item registers, bitmap memory with row valid bits, watermark walker.
`default_nettype none

module crbt_datapath
  import crbt_pkg::*;
#(
  parameter int BITMAP_BYTES = 1024
)(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  cmd,
  input  wire item_t item_data,
  output status_t    status,
  output result_t    result_data
);

  localparam int CAPACITY = BITMAP_BYTES * 8;
  localparam int WORDS    = (BITMAP_BYTES + 7) / 8;
  localparam int AW       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMP_W    = 17;

  localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

  item_t                 item_r;
  logic [1:0]            err_code;
  logic [CNT_W-1:0]      ptr;
  logic [CNT_W-1:0]      total;
  logic [WORD_BITS-1:0]  mem [WORDS];
  logic [WORDS-1:0]      vbits;
  logic [WORD_BITS-1:0]  rdata;
  logic                  rvalid;
  logic [AW-1:0]         mark_addr;
  logic [AW-1:0]         walk_addr;
  logic [AW-1:0]         rd_addr;
  logic [WORD_BITS-1:0]  word;
  logic [WORD_BITS-1:0]  wdata;
  logic [OFF_W-1:0]      off;
  logic [WORD_BITS-1:0]  sh;
  logic [RUN_W-1:0]      run;
  logic [RUN_W-1:0]      room;
  logic [CNT_W:0]        sum;
  logic [CNT_W-1:0]      ptr_next;

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= item_data;
    end
  end

  // Classify the item: an oversized total wins over a bad index
  always_comb begin
    priority if ({1'b0, item_r.total_chunks} > CAP_C) begin
      err_code = ERR_TOTAL;
    end else if (item_r.kind == KIND_MARK && {1'b0, item_r.chunk_index} >= CAP_C) begin
      err_code = ERR_INDEX;
    end else begin
      err_code = ERR_OK;
    end
  end

  assign mark_addr = item_r.chunk_index[OFF_W +: AW];
  assign walk_addr = ptr[OFF_W +: AW];
  assign rd_addr   = cmd.rd_mark ? mark_addr : walk_addr;

  // Bitmap memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_mark) begin
      mem[mark_addr] <= wdata;
    end
    if (cmd.rd_mark || cmd.rd_walk) begin
      rdata  <= mem[rd_addr];
      rvalid <= vbits[rd_addr];
    end
  end

  // Row valid bits: a row never written since reset or start reads as zero
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vbits <= '0;
    end else if (cmd.wr_mark) begin
      vbits[mark_addr] <= 1'b1;
    end
  end

  assign word  = rvalid ? rdata : '0;
  assign wdata = word | (WORD_BITS'(1) << item_r.chunk_index[OFF_W-1:0]);

  // Count consecutive set bits upward from the watermark within the current word
  assign off = ptr[OFF_W-1:0];
  assign sh  = word >> off;

  always_comb begin
    run = RUN_W'(WORD_BITS);
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!sh[i]) begin
        run = RUN_W'(i);
      end
    end
  end

  assign room     = RUN_W'(WORD_BITS) - {1'b0, off};
  assign sum      = {1'b0, ptr} + (CNT_W + 1)'(run);
  assign ptr_next = (sum > {1'b0, total}) ? total : sum[CNT_W-1:0];

  // Watermark and total
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      total <= '0;
    end else begin
      if (cmd.clear) begin
        ptr <= '0;
      end else if (cmd.step_walk) begin
        ptr <= ptr_next;
      end
      if (cmd.clear || cmd.set_total) begin
        total <= CNT_W'(item_r.total_chunks);
      end
    end
  end

  assign status.err       = (err_code != ERR_OK);
  assign status.is_start  = (item_r.kind == KIND_START);
  assign status.walk_more = (ptr < total);
  assign status.walk_cont = (run == room);

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result_data.all_received <= (ptr >= total);
      result_data.watermark    <= WM_W'(ptr);
      result_data.error        <= err_code;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/chunk_receive_bitmap_tracker_core.sv */
// Top level of the chunk receive bitmap tracker: controller, datapath and checks.
//
//   channel  modport  payload
//   -------  -------  ------------------------------------------
//   item     sink     kind, chunk_index, total_chunks
//   result   source   all_received, watermark, error
//
// One item at a time. A start or rejected item goes from decode straight to the
// output register; a mark item reads and writes its bitmap row, then, while the
// watermark is below the total, reads and steps over one bitmap word at a time
// until a word ends the run of received chunks or the total is met.
// Reset clears the bitmap row valid bits, watermark and total at once.
// A result waits in the output register while the next item is taken; a second
// finished result holds the controller, and so the input, until that register frees.
`default_nettype none

module chunk_receive_bitmap_tracker_core
  import crbt_pkg::*;
#(
  parameter int BITMAP_BYTES = 1024
)(
  input wire logic      clk,
  input wire logic      rst,
  crbt_item_if.sink     item,
  crbt_result_if.source result
);

  cmd_t    cmd;
  status_t status;

  crbt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  crbt_datapath #(
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .item_data   (item.data),
    .status      (status),
    .result_data (result.data)
  );

  // One item in flight: no transfer right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("item taken while another is in flight");

  // Never overwrite a result that the sink has not taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!result.valid || result.ready))
    else $error("result register overwritten");

  // The bitmap write always follows the read of the same row
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_mark |-> $past(cmd.rd_mark))
    else $error("bitmap write without preceding read");

  // Mark read and walk read never collide on the read port
  a_read_port: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.rd_mark, cmd.rd_walk}))
    else $error("two reads issued in one cycle");

endmodule

`default_nettype wire

/* tb/crbt_scoreboard_pkg.sv */
// Scoreboard class for the chunk receive bitmap tracker testbench.
package crbt_scoreboard_pkg;
  import crbt_pkg::*;

  class bitmap_scoreboard;
    int unsigned          capacity;
    logic [WORD_BITS-1:0] rows [];
    int unsigned          done_ptr;
    int unsigned          chunk_total;
    result_t              expected_q [$];
    int                   mismatches;
    int                   results_checked;
    int                   total_rejects;
    int                   index_rejects;

    function new(int unsigned bitmap_bytes);
      capacity = bitmap_bytes * 8;
      rows = new[(bitmap_bytes + 7) / 8];
      foreach (rows[w]) rows[w] = '0;
      done_ptr = 0;
      chunk_total = 0;
      mismatches = 0;
      results_checked = 0;
      total_rejects = 0;
      index_rejects = 0;
    endfunction

    function bit chunk_present(int unsigned idx);
      if (idx >= capacity || (idx >> 6) >= rows.size()) return 1'b0;
      return rows[idx >> 6][idx % WORD_BITS];
    endfunction

    // Apply one accepted item to the shadow bitmap and queue its status.
    function void note_item(item_t it);
      logic [1:0] err;
      result_t    exp_r;
      err = ERR_OK;
      if (it.total_chunks > capacity) begin
        err = ERR_TOTAL;
        total_rejects++;
      end else if (it.kind == KIND_START) begin
        foreach (rows[w]) rows[w] = '0;
        done_ptr = 0;
        chunk_total = 32'(it.total_chunks);
      end else if (it.chunk_index >= capacity || (it.chunk_index >> 6) >= rows.size()) begin
        err = ERR_INDEX;
        index_rejects++;
      end else begin
        chunk_total = 32'(it.total_chunks);
        rows[it.chunk_index >> 6][it.chunk_index[5:0]] = 1'b1;
      end
      // advance the watermark over consecutive received chunks, capped at the total
      while (done_ptr < chunk_total && chunk_present(done_ptr)) done_ptr++;
      exp_r.all_received = (done_ptr >= chunk_total);
      exp_r.watermark    = done_ptr[WM_W-1:0];
      exp_r.error        = err;
      expected_q.push_back(exp_r);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag_field(string field, logic [15:0] exp_v, logic [15:0] got_v, time stamp);
      mismatches++;
      $display("%0d ns: %s mismatch: expected %0d, got %0d", stamp, field, exp_v, got_v);
    endfunction

    // Compare one result transfer against the oldest queued status.
    function void check_result(result_t got, time stamp);
      result_t exp_r;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0d ns: result with nothing expected: all_received=%0b watermark=%0d error=%0d",
                 stamp, got.all_received, got.watermark, got.error);
        return;
      end
      exp_r = expected_q.pop_front();
      results_checked++;
      if (got.all_received !== exp_r.all_received)
        flag_field("all_received", 16'(exp_r.all_received), 16'(got.all_received), stamp);
      if (got.watermark !== exp_r.watermark)
        flag_field("watermark", 16'(exp_r.watermark), 16'(got.watermark), stamp);
      if (got.error !== exp_r.error)
        flag_field("error", 16'(exp_r.error), 16'(got.error), stamp);
    endfunction
  endclass

endpackage

/* tb/chunk_receive_bitmap_tracker_core_test.sv */
// Top-level testbench for the chunk receive bitmap tracker core.
module chunk_receive_bitmap_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import crbt_pkg::*;
  import crbt_scoreboard_pkg::*;

  localparam int BITMAP_BYTES  = 1024;
  localparam int CAPACITY      = BITMAP_BYTES * 8;
  localparam int RANDOM_ITEMS  = 850;
  localparam int MAX_MARKS     = 96;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 20;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_EVERY_THIRD, SINK_SPARSE} sink_mode_t;

  logic clk;
  logic rst;

  crbt_item_if   item_ch ();
  crbt_result_if result_ch ();

  chunk_receive_bitmap_tracker_core #(
    .BITMAP_BYTES(BITMAP_BYTES)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  bitmap_scoreboard sb;
  int items_sent;
  int transfers_started;
  int burst_left;
  bit gaps_on;
  int hold_token;

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #3_000_000;
    $display("chunk_receive_bitmap_tracker_core_test: done, errors");
    $finish;
  end

  // Check result transfers and drive ready on a stall pattern of its own
  initial begin : result_sink
    sink_mode_t mode;
    int phase_left;
    int tick;
    int hold_seen;
    int hold_left;
    result_ch.ready <= 1'b0;
    mode = SINK_OPEN;
    phase_left = 0;
    tick = 0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) sb.check_result(result_ch.data, $time);
      // load a long hold-off when the stimulus asks for one
      if (hold_seen != hold_token) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      tick++;
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        result_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        case (mode)
          SINK_OPEN:        result_ch.ready <= 1'b1;
          SINK_COIN:        result_ch.ready <= 1'($urandom_range(0, 1));
          SINK_EVERY_THIRD: result_ch.ready <= (tick % 3 == 0);
          default:          result_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  function automatic item_t make_item(logic kind, int idx, int total);
    item_t it;
    it.kind         = kind;
    it.chunk_index  = idx[15:0];
    it.total_chunks = total[15:0];
    return it;
  endfunction

  function automatic item_t noise_item();
    return make_item(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                     $urandom_range(0, 65535));
  endfunction

  // Offer one item, hold it until the transfer, then maybe close the burst
  task automatic send_item(input item_t it);
    item_ch.valid <= 1'b1;
    item_ch.data  <= it;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_item(it);
    items_sent++;
    if (gaps_on) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        item_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  // Stop offering and wait until every queued status has come back
  task automatic wait_drain();
    if (item_ch.valid) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Corner cases: zero total, lowered total, top of capacity, both rejections
  task automatic directed_items();
    send_item(make_item(KIND_START, 0, 0));
    send_item(make_item(KIND_MARK, 0, 0));
    send_item(make_item(KIND_MARK, 1, 3));
    send_item(make_item(KIND_MARK, 5, 3));
    send_item(make_item(KIND_MARK, 2, 3));
    send_item(make_item(KIND_MARK, 3, 6));
    send_item(make_item(KIND_MARK, 4, 2));
    send_item(make_item(KIND_MARK, 6, 8));
    send_item(make_item(KIND_START, 0, CAPACITY + 1));
    send_item(make_item(KIND_MARK, 65535, 65535));
    send_item(make_item(KIND_MARK, CAPACITY, 8));
    send_item(make_item(KIND_MARK, 65535, 8));
    send_item(make_item(KIND_MARK, CAPACITY - 1, CAPACITY + 1));
    send_item(make_item(KIND_MARK, 7, CAPACITY));
    send_item(make_item(KIND_MARK, CAPACITY - 1, CAPACITY));
    send_item(make_item(KIND_START, 65535, CAPACITY));
    send_item(make_item(KIND_MARK, 0, CAPACITY));
    send_item(make_item(KIND_START, 0, 65535));
    send_item(make_item(KIND_START, 0, 1));
    send_item(make_item(KIND_MARK, 0, 1));
    send_item(make_item(KIND_MARK, 63, 0));
    send_item(make_item(KIND_MARK, 64, 0));
  endtask

  // One transfer: a start, then marks in order, reversed or shuffled,
  // with lost chunks, total changes and faulty items mixed in
  task automatic run_transfer();
    int total;
    int marks;
    int pick;
    int tmp;
    int j;
    int order [MAX_MARKS];
    pick = $urandom_range(0, 99);
    if (pick < 5) total = 0;
    else if (pick < 70) total = $urandom_range(1, 64);
    else if (pick < 92) total = $urandom_range(65, 300);
    else total = $urandom_range(301, CAPACITY);
    send_item(make_item(KIND_START, $urandom_range(0, 65535), total));
    transfers_started++;
    marks = (total < MAX_MARKS) ? total : MAX_MARKS;
    for (int k = 0; k < marks; k++) order[k] = k;
    pick = $urandom_range(0, 2);
    if (pick == 1) begin
      for (int k = 0; k < marks; k++) order[k] = marks - 1 - k;
    end else if (pick == 2) begin
      for (int k = marks - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        tmp = order[k];
        order[k] = order[j];
        order[j] = tmp;
      end
    end
    for (int k = 0; k < marks; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        continue;
      end else if (pick < 80) begin
        send_item(make_item(KIND_MARK, order[k], total));
      end else if (pick < 86) begin
        send_item(make_item(KIND_MARK, order[k],
                            $urandom_range(0, (total + 16 > CAPACITY) ? CAPACITY : total + 16)));
      end else if (pick < 90) begin
        send_item(make_item(KIND_MARK,
                            (total < CAPACITY) ? $urandom_range(total, CAPACITY - 1) : order[k],
                            total));
      end else if (pick < 94) begin
        send_item(make_item(KIND_MARK, $urandom_range(CAPACITY, 65535), total));
      end else if (pick < 97) begin
        send_item(make_item(1'($urandom_range(0, 1)), $urandom_range(0, 65535),
                            $urandom_range(CAPACITY + 1, 65535)));
      end else begin
        send_item(noise_item());
      end
    end
  endtask

  initial begin : stimulus
    int random_target;
    bit hold_done;
    sb = new(BITMAP_BYTES);
    rst <= 1'b1;
    item_ch.valid <= 1'b0;
    item_ch.data  <= '0;
    items_sent = 0;
    transfers_started = 0;
    burst_left = 0;
    gaps_on = 1'b1;
    hold_token = 0;
    hold_done = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    wait_drain();

    random_target = items_sent + RANDOM_ITEMS;
    while (items_sent < random_target) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      // stall the receiver for a long stretch while items keep coming
      if (!hold_done && items_sent > RANDOM_ITEMS / 3) begin
        hold_done = 1'b1;
        gaps_on = 1'b0;
        hold_token++;
        repeat (8) send_item(noise_item());
        wait_drain();
      end
      run_transfer();
      if ($urandom_range(0, 5) == 0) wait_drain();
    end

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d items over %0d random transfers, %0d results checked.",
             items_sent, transfers_started, sb.results_checked);
    $display("Rejections seen: %0d oversized totals, %0d out-of-range indexes.",
             sb.total_rejects, sb.index_rejects);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("chunk_receive_bitmap_tracker_core_test: done, clean");
    end else begin
      $display("chunk_receive_bitmap_tracker_core_test: done, errors");
    end
    $finish;
  end

endmodule
